// File: design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define TBN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/tbn_pkg.sv
// ----------------------------------------------------------------------------
// tbn_pkg
// Types and constants of the triangle tangent and binormal block.
// ----------------------------------------------------------------------------
package tbn_pkg;

  localparam int PosBits   = 32;
  localparam int TexBits   = 20;
  localparam int EdgeBits  = PosBits + 1;
  localparam int DeltaBits = TexBits + 1;
  localparam int ProdBits  = EdgeBits + DeltaBits;
  localparam int NumBits   = ProdBits + 1;
  localparam int NormBits  = 30;
  localparam int OutBits   = 16;
  localparam int UnitOne   = 16384;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusZeroDet = 2'd1,
    StatusZeroLen = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BkIdle,
    BkMul,
    BkCheck,
    BkLoad,
    BkNorm,
    BkSquare,
    BkSqrt,
    BkDivInit,
    BkDiv,
    BkDone
  } back_state_e;

  typedef struct packed {
    logic signed [PosBits-1:0] pos_x;
    logic signed [PosBits-1:0] pos_y;
    logic signed [PosBits-1:0] pos_z;
    logic signed [TexBits-1:0] tex_u;
    logic signed [TexBits-1:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [OutBits-1:0] tangent_x;
    logic signed [OutBits-1:0] tangent_y;
    logic signed [OutBits-1:0] tangent_z;
    logic signed [OutBits-1:0] binormal_x;
    logic signed [OutBits-1:0] binormal_y;
    logic signed [OutBits-1:0] binormal_z;
    logic [1:0]                status;
  } out_item_t;

  // Edge vectors and texture deltas of one complete triangle.
  typedef struct packed {
    logic signed [EdgeBits-1:0]  e1x;
    logic signed [EdgeBits-1:0]  e1y;
    logic signed [EdgeBits-1:0]  e1z;
    logic signed [EdgeBits-1:0]  e2x;
    logic signed [EdgeBits-1:0]  e2y;
    logic signed [EdgeBits-1:0]  e2z;
    logic signed [DeltaBits-1:0] du1;
    logic signed [DeltaBits-1:0] dv1;
    logic signed [DeltaBits-1:0] du2;
    logic signed [DeltaBits-1:0] dv2;
  } job_t;

endpackage

// File: design/tbn_front.sv
// ----------------------------------------------------------------------------
// tbn_front
// Collects corners; on the third one forms edges and texture deltas.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tbn_pkg::in_item_t in_item_i,
  output logic             job_valid_o,
  input  logic             job_stall_i,
  output tbn_pkg::job_t    job_o
);

  logic [1:0]             corner_q, corner_d;
  tbn_pkg::in_item_t      c1_q, c2_q;
  logic                   take;
  logic                   third;

  assign third       = (corner_q == 2'd2);
  assign in_stall_o  = third && job_stall_i;
  assign job_valid_o = in_valid_i && third;
  assign take        = in_valid_i && !in_stall_o;

  // Deltas against the first corner.
  assign job_o.e1x = tbn_pkg::EdgeBits'(c2_q.pos_x) - tbn_pkg::EdgeBits'(c1_q.pos_x);
  assign job_o.e1y = tbn_pkg::EdgeBits'(c2_q.pos_y) - tbn_pkg::EdgeBits'(c1_q.pos_y);
  assign job_o.e1z = tbn_pkg::EdgeBits'(c2_q.pos_z) - tbn_pkg::EdgeBits'(c1_q.pos_z);
  assign job_o.e2x = tbn_pkg::EdgeBits'(in_item_i.pos_x) - tbn_pkg::EdgeBits'(c1_q.pos_x);
  assign job_o.e2y = tbn_pkg::EdgeBits'(in_item_i.pos_y) - tbn_pkg::EdgeBits'(c1_q.pos_y);
  assign job_o.e2z = tbn_pkg::EdgeBits'(in_item_i.pos_z) - tbn_pkg::EdgeBits'(c1_q.pos_z);
  assign job_o.du1 = tbn_pkg::DeltaBits'(c2_q.tex_u) - tbn_pkg::DeltaBits'(c1_q.tex_u);
  assign job_o.dv1 = tbn_pkg::DeltaBits'(c2_q.tex_v) - tbn_pkg::DeltaBits'(c1_q.tex_v);
  assign job_o.du2 = tbn_pkg::DeltaBits'(in_item_i.tex_u) - tbn_pkg::DeltaBits'(c1_q.tex_u);
  assign job_o.dv2 = tbn_pkg::DeltaBits'(in_item_i.tex_v) - tbn_pkg::DeltaBits'(c1_q.tex_v);

  // Corner counter.
  always_comb begin
    corner_d = corner_q;
    if (take) begin
      corner_d = third ? 2'd0 : corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
    end else begin
      corner_q <= corner_d;
    end
  end

  // Held corners.
  always_ff @(posedge clk_i) begin
    if (take && corner_q == 2'd0) begin
      c1_q <= in_item_i;
    end
    if (take && corner_q == 2'd1) begin
      c2_q <= in_item_i;
    end
  end

  `TBN_ASSERT(a_corner_range, corner_q != 2'd3, "corner count out of range")
  `TBN_ASSERT_NEXT(a_third_wraps, take && third, corner_q == 2'd0, "count did not wrap")

endmodule

// File: design/tbn_queue.sv
// ----------------------------------------------------------------------------
// tbn_queue
// Two-entry queue of triangle jobs between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_stall_o,
  input  tbn_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_stall_i,
  output tbn_pkg::job_t pop_data_o
);

  tbn_pkg::job_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_stall_o = (count_q == 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  `TBN_ASSERT(a_count_range, count_q != 2'd3, "queue overfilled")
  `TBN_ASSERT(a_ptr_match, (count_q == 2'd0 || count_q == 2'd2) == (wptr_q == rptr_q),
    "pointers disagree with fill count")
  `TBN_ASSERT_NEXT(a_grow, push && !pop, count_q == $past(count_q) + 2'd1, "count not grown")

endmodule

// File: design/tbn_back.sv
// ----------------------------------------------------------------------------
// tbn_back
// Iterative back end: cross products, normalization, square root and divides.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_stall_o,
  input  tbn_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbn_pkg::out_item_t out_item_o
);

  localparam int EB = tbn_pkg::EdgeBits;
  localparam int DB = tbn_pkg::DeltaBits;
  localparam int PB = tbn_pkg::ProdBits;
  localparam int NB = tbn_pkg::NumBits;
  localparam int RB = tbn_pkg::NormBits;
  localparam int OB = tbn_pkg::OutBits;
  localparam int LastStep = 13;

  tbn_pkg::back_state_e state_q, state_d;
  tbn_pkg::job_t        job_q;

  logic [3:0]           step_q, pstep_q;
  logic                 pvalid_q;
  logic signed [DB-1:0] mul_a;
  logic signed [EB-1:0] mul_b;
  logic signed [PB-1:0] prod_w, prod_q, first_q;
  logic signed [NB-1:0] diff_w, det_q;
  logic signed [NB-1:0] num_q [6];

  logic                 sel_q;
  logic [1:0]           kidx_q;
  logic [NB-1:0]        m_q [3];
  logic                 sgn_q [3];
  logic [NB-1:0]        mor;
  logic [2*RB-1:0]      sq_q;
  logic [63:0]          sum_q, n_q, res_q, bit_q, sq_t;
  logic [4:0]           cnt_q;
  logic [31:0]          len_q;
  logic [47:0]          rem_q, dsh_q;
  logic [OB-1:0]        quo_q, quo_w, qsigned;
  logic                 ge;
  logic signed [OB-1:0] vec_q [6];
  logic [1:0]           status_q;
  logic                 det_zero, vec_zero, mul_last, div_last, out_free;

  tbn_pkg::out_item_t   out_q;
  logic                 out_valid_q;

  function automatic logic [NB-1:0] mag(input logic signed [NB-1:0] v);
    return v[NB-1] ? (~v + 1'b1) : v;
  endfunction

  assign job_stall_o = (state_q != tbn_pkg::BkIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Operand schedule of the shared multiplier: determinant, tangent, binormal.
  always_comb begin
    mul_a = job_q.du1;
    mul_b = EB'(job_q.dv2);
    case (step_q)
      4'd0:  begin mul_a = job_q.du1; mul_b = EB'(job_q.dv2); end
      4'd1:  begin mul_a = job_q.du2; mul_b = EB'(job_q.dv1); end
      4'd2:  begin mul_a = job_q.dv2; mul_b = job_q.e1x; end
      4'd3:  begin mul_a = job_q.dv1; mul_b = job_q.e2x; end
      4'd4:  begin mul_a = job_q.dv2; mul_b = job_q.e1y; end
      4'd5:  begin mul_a = job_q.dv1; mul_b = job_q.e2y; end
      4'd6:  begin mul_a = job_q.dv2; mul_b = job_q.e1z; end
      4'd7:  begin mul_a = job_q.dv1; mul_b = job_q.e2z; end
      4'd8:  begin mul_a = job_q.du1; mul_b = job_q.e2x; end
      4'd9:  begin mul_a = job_q.du2; mul_b = job_q.e1x; end
      4'd10: begin mul_a = job_q.du1; mul_b = job_q.e2y; end
      4'd11: begin mul_a = job_q.du2; mul_b = job_q.e1y; end
      4'd12: begin mul_a = job_q.du1; mul_b = job_q.e2z; end
      4'd13: begin mul_a = job_q.du2; mul_b = job_q.e1z; end
      default: begin mul_a = job_q.du1; mul_b = EB'(job_q.dv2); end
    endcase
  end

  assign prod_w   = mul_a * mul_b;
  assign diff_w   = first_q - prod_q;
  assign mul_last = pvalid_q && (pstep_q == 4'(LastStep));
  assign det_zero = (det_q == '0);
  assign vec_zero = (num_q[0] == '0 && num_q[1] == '0 && num_q[2] == '0) ||
                    (num_q[3] == '0 && num_q[4] == '0 && num_q[5] == '0);
  assign mor      = m_q[0] | m_q[1] | m_q[2];
  assign sq_t     = res_q + bit_q;
  assign ge       = (rem_q >= dsh_q);
  assign quo_w    = {quo_q[OB-2:0], ge};
  assign qsigned  = sgn_q[0] ? (~quo_w + 1'b1) : quo_w;
  assign div_last = (cnt_q == 5'(OB - 1));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbn_pkg::BkIdle:    if (job_valid_i) state_d = tbn_pkg::BkMul;
      tbn_pkg::BkMul:     if (mul_last) state_d = tbn_pkg::BkCheck;
      tbn_pkg::BkCheck:   state_d = (det_zero || vec_zero) ? tbn_pkg::BkDone
                                                          : tbn_pkg::BkLoad;
      tbn_pkg::BkLoad:    state_d = tbn_pkg::BkNorm;
      tbn_pkg::BkNorm: begin
        if (mor[NB-1:RB] == '0 && mor[RB-1]) state_d = tbn_pkg::BkSquare;
      end
      tbn_pkg::BkSquare:  if (cnt_q == 5'd3) state_d = tbn_pkg::BkSqrt;
      tbn_pkg::BkSqrt:    if (cnt_q == 5'd31) state_d = tbn_pkg::BkDivInit;
      tbn_pkg::BkDivInit: state_d = tbn_pkg::BkDiv;
      tbn_pkg::BkDiv: begin
        if (div_last) begin
          if (kidx_q != 2'd2) state_d = tbn_pkg::BkDivInit;
          else if (!sel_q) state_d = tbn_pkg::BkLoad;
          else state_d = tbn_pkg::BkDone;
        end
      end
      tbn_pkg::BkDone:    if (out_free) state_d = tbn_pkg::BkIdle;
      default:            state_d = tbn_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbn_pkg::BkIdle;
      out_valid_q <= 1'b0;
      pvalid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pvalid_q <= (state_q == tbn_pkg::BkMul) && (step_q <= 4'(LastStep));
      if (state_q == tbn_pkg::BkDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    pstep_q <= step_q;
    prod_q  <= prod_w;
    case (state_q)
      tbn_pkg::BkIdle: begin
        job_q  <= job_i;
        step_q <= 4'd0;
      end
      tbn_pkg::BkMul: begin
        if (step_q <= 4'(LastStep)) begin
          step_q <= step_q + 4'd1;
        end
        // Combine pairs of products by subtraction into determinant and numerators.
        if (pvalid_q) begin
          if (!pstep_q[0]) begin
            first_q <= prod_q;
          end else if (pstep_q[3:1] == 3'd0) begin
            det_q <= diff_w;
          end else begin
            for (int i = 0; i < 5; i++) num_q[i] <= num_q[i+1];
            num_q[5] <= diff_w;
          end
        end
      end
      tbn_pkg::BkCheck: begin
        sel_q <= 1'b0;
        for (int i = 0; i < 6; i++) vec_q[i] <= '0;
        if (det_zero) begin
          status_q <= tbn_pkg::StatusZeroDet;
        end else if (vec_zero) begin
          status_q <= tbn_pkg::StatusZeroLen;
        end else begin
          status_q <= tbn_pkg::StatusOk;
        end
      end
      tbn_pkg::BkLoad: begin
        kidx_q <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= mag(sel_q ? num_q[i+3] : num_q[i]);
          sgn_q[i] <= (sel_q ? num_q[i+3][NB-1] : num_q[i][NB-1]) ^ det_q[NB-1];
        end
      end
      tbn_pkg::BkNorm: begin
        // Bring the largest magnitude to exactly RB bits, up to 8 bits a step.
        for (int i = 0; i < 3; i++) begin
          if (mor[NB-1:RB+8] != '0) begin
            m_q[i] <= m_q[i] >> 8;
          end else if (mor[NB-1:RB] != '0) begin
            m_q[i] <= m_q[i] >> 1;
          end else if (mor[RB-1:RB-8] == '0) begin
            m_q[i] <= m_q[i] << 8;
          end else if (!mor[RB-1]) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
        cnt_q <= 5'd0;
        sum_q <= '0;
      end
      tbn_pkg::BkSquare: begin
        // Sum of squares; the component line rotates so slot zero is squared.
        if (cnt_q < 5'd3) begin
          sq_q   <= m_q[0][RB-1:0] * m_q[0][RB-1:0];
          m_q[0] <= m_q[1];
          m_q[1] <= m_q[2];
          m_q[2] <= m_q[0];
        end
        if (cnt_q != 5'd0) begin
          sum_q <= sum_q + 64'(sq_q);
        end
        n_q   <= sum_q + 64'(sq_q);
        res_q <= '0;
        bit_q <= 64'd1 << 62;
        cnt_q <= (cnt_q == 5'd3) ? 5'd0 : cnt_q + 5'd1;
      end
      tbn_pkg::BkSqrt: begin
        // One result bit of the integer square root per cycle.
        if (n_q >= sq_t) begin
          n_q   <= n_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          len_q <= (n_q >= sq_t) ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
        end
      end
      tbn_pkg::BkDivInit: begin
        rem_q <= {3'b000, m_q[0][RB-1:0], 15'd0} + 48'(len_q);
        dsh_q <= {len_q, 16'd0};
        quo_q <= '0;
        cnt_q <= 5'd0;
      end
      tbn_pkg::BkDiv: begin
        // Restoring division by twice the length, one quotient bit a cycle.
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_w;
        cnt_q <= cnt_q + 5'd1;
        if (div_last) begin
          for (int i = 0; i < 5; i++) vec_q[i] <= vec_q[i+1];
          vec_q[5] <= qsigned;
          m_q[0]   <= m_q[1];
          m_q[1]   <= m_q[2];
          m_q[2]   <= m_q[0];
          sgn_q[0] <= sgn_q[1];
          sgn_q[1] <= sgn_q[2];
          sgn_q[2] <= sgn_q[0];
          kidx_q   <= kidx_q + 2'd1;
          if (kidx_q == 2'd2) begin
            sel_q <= 1'b1;
          end
        end
      end
      tbn_pkg::BkDone: begin
        if (out_free) begin
          out_q.tangent_x  <= vec_q[0];
          out_q.tangent_y  <= vec_q[1];
          out_q.tangent_z  <= vec_q[2];
          out_q.binormal_x <= vec_q[3];
          out_q.binormal_y <= vec_q[4];
          out_q.binormal_z <= vec_q[5];
          out_q.status     <= status_q;
        end
      end
      default: begin
        step_q <= 4'd0;
      end
    endcase
  end

  `TBN_ASSERT(a_len_nonzero, (state_q == tbn_pkg::BkDiv) -> (len_q != '0),
    "division by a zero length")
  `TBN_ASSERT(a_quo_range, (state_q == tbn_pkg::BkDiv && div_last) -> (quo_w <= 16'd16384),
    "unit component above one")
  `TBN_ASSERT(a_fail_zero, (out_valid_q && out_q.status != tbn_pkg::StatusOk) ->
    (out_q.tangent_x == '0 && out_q.binormal_z == '0), "failed triangle has nonzero vectors")

endmodule

// File: design/triangle_tangent_binormal.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal
// Tangent and binormal of a textured triangle, one corner per transfer.
// ----------------------------------------------------------------------------
// Corners arrive one per transfer. The first two are held and taken without
// stalling. The third completes the triangle and moves as one job through a
// two-entry queue to an iterative back end, which emits one result per
// triangle. The back end accepts a job, forms the determinant and both
// numerators on the shared 21x33 multiplier and checks them. If both pass,
// each vector then takes a load, normalizing shifts, the sum of squares, the
// bit-serial square root and three restoring divides before the result is
// handed off. The square root and divide loops take most of the back end's
// time. While the back end works, up to two more complete triangles are
// accepted into the queue. A finished result waits in the output register
// while the back end works on its next job, which then waits in its done
// state until the register is free.
// Status 1 marks a zero texture determinant, status 2 a zero vector.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbn_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbn_pkg::out_item_t out_item_o
);

  logic          fq_valid, fq_stall, qb_valid, qb_stall;
  tbn_pkg::job_t fq_job, qb_job;

  // Corner collection and edge forming.
  tbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_valid_o (fq_valid),
    .job_stall_i (fq_stall),
    .job_o       (fq_job)
  );

  // Job queue.
  tbn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_stall_i  (qb_stall),
    .pop_data_o   (qb_job)
  );

  // Iterative basis computation.
  tbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_stall_o (qb_stall),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/sv/triangle_tangent_binormal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_tb
// Self-checking bench for the triangle tangent and binormal block.
// ----------------------------------------------------------------------------
// Corners are sent in triangles, first a handful of hand-built corner cases
// (zero texture determinant, zero edge vectors, extreme positions and texture
// coordinates, both determinant signs) and then several hundred random
// triangles of mixed magnitude. A bit-exact model in the bench predicts the
// unit tangent and binormal of each triangle, and every result transfer is
// compared field by field. The sender works in random bursts and the receiver
// stalls in changing patterns.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_tb;

  typedef logic signed [127:0] wide_t;

  localparam int NumRandomTris = 444;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  tbn_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  tbn_pkg::out_item_t out_item_o;

  tbn_pkg::in_item_t  corner_q[$];
  tbn_pkg::out_item_t basis_q[$];
  int                 num_errors;
  int                 num_results;
  int                 num_zero_det;
  int                 num_zero_len;

  // Corners held by the model until a triangle is complete.
  longint    held_pos[6];
  longint    held_tex[4];
  int        held_count;

  triangle_tangent_binormal i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic wide_t wmul(longint a, longint b);
    wide_t x;
    wide_t y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic int bit_length(logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit vector of (v0, v1, v2) times the sign of the determinant, Q1.14,
  // packed x in the top bits.
  function automatic logic [47:0] unit_q14(wide_t v0, wide_t v1, wide_t v2, bit det_neg);
    wide_t           v[3];
    logic [127:0]    m[3];
    longint unsigned c[3];
    longint unsigned acc;
    longint unsigned len;
    longint unsigned q;
    int              maxl;
    logic [47:0]     r;
    v[0] = v0;
    v[1] = v1;
    v[2] = v2;
    maxl = 0;
    acc  = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (bit_length(m[i]) > maxl) maxl = bit_length(m[i]);
    end
    // Scale so that the largest magnitude is exactly NormBits long.
    for (int i = 0; i < 3; i++) begin
      if (maxl > tbn_pkg::NormBits) c[i] = 64'(m[i] >> (maxl - tbn_pkg::NormBits));
      else c[i] = 64'(m[i] << (tbn_pkg::NormBits - maxl));
      acc += c[i] * c[i];
    end
    len = int_sqrt(acc);
    for (int i = 0; i < 3; i++) begin
      q = (c[i] * (2 * tbn_pkg::UnitOne) + len) / (2 * len);
      if ((v[i] < 0) != det_neg) q = -q;
      r[47 - 16 * i -: 16] = q[15:0];
    end
    return r;
  endfunction

  // Model of one accepted corner; a completed triangle queues its basis.
  task automatic take_corner(tbn_pkg::in_item_t it);
    longint             e1[3];
    longint             e2[3];
    longint             pu;
    longint             pv;
    longint             du1;
    longint             dv1;
    longint             du2;
    longint             dv2;
    longint             p[3];
    wide_t              det;
    wide_t              tg[3];
    wide_t              bn[3];
    tbn_pkg::out_item_t res;
    logic [47:0]        tv;
    logic [47:0]        bv;
    p[0] = longint'(it.pos_x);
    p[1] = longint'(it.pos_y);
    p[2] = longint'(it.pos_z);
    pu = longint'(it.tex_u);
    pv = longint'(it.tex_v);
    if (held_count < 2) begin
      for (int i = 0; i < 3; i++) held_pos[held_count * 3 + i] = p[i];
      held_tex[held_count * 2]     = pu;
      held_tex[held_count * 2 + 1] = pv;
      held_count++;
    end else begin
      held_count = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = held_pos[3 + i] - held_pos[i];
        e2[i] = p[i] - held_pos[i];
      end
      du1 = held_tex[2] - held_tex[0];
      dv1 = held_tex[3] - held_tex[1];
      du2 = pu - held_tex[0];
      dv2 = pv - held_tex[1];
      res = '0;
      det = wmul(du1, dv2) - wmul(du2, dv1);
      if (det == 0) begin
        res.status = tbn_pkg::StatusZeroDet;
      end else begin
        for (int i = 0; i < 3; i++) begin
          tg[i] = wmul(dv2, e1[i]) - wmul(dv1, e2[i]);
          bn[i] = wmul(du1, e2[i]) - wmul(du2, e1[i]);
        end
        if ((tg[0] == 0 && tg[1] == 0 && tg[2] == 0) ||
            (bn[0] == 0 && bn[1] == 0 && bn[2] == 0)) begin
          res.status = tbn_pkg::StatusZeroLen;
        end else begin
          tv = unit_q14(tg[0], tg[1], tg[2], det < 0);
          bv = unit_q14(bn[0], bn[1], bn[2], det < 0);
          res.tangent_x  = tv[47:32];
          res.tangent_y  = tv[31:16];
          res.tangent_z  = tv[15:0];
          res.binormal_x = bv[47:32];
          res.binormal_y = bv[31:16];
          res.binormal_z = bv[15:0];
          res.status     = tbn_pkg::StatusOk;
        end
      end
      basis_q.insert(basis_q.size(), res);
    end
  endtask

  // Driver: bursts of corners separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      held_count = 0;
      foreach (held_pos[i]) held_pos[i] = 0;
      foreach (held_tex[i]) held_tex[i] = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_corner(in_item_i);
        void'(corner_q.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (corner_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= corner_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
    num_errors++;
  endtask

  // Monitor: stalls in changing patterns and checks each result transfer.
  int stall_mode;
  int stall_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    tbn_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_cnt   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (basis_q.size() == 0) begin
          $display("%0t: result transfer with no triangle outstanding", $realtime);
          num_errors++;
        end else begin
          want = basis_q.pop_front();
          num_results++;
          if (want.status == tbn_pkg::StatusZeroDet) num_zero_det++;
          if (want.status == tbn_pkg::StatusZeroLen) num_zero_len++;
          if (out_item_o.tangent_x !== want.tangent_x)
            report("tangent_x", out_item_o.tangent_x, want.tangent_x);
          if (out_item_o.tangent_y !== want.tangent_y)
            report("tangent_y", out_item_o.tangent_y, want.tangent_y);
          if (out_item_o.tangent_z !== want.tangent_z)
            report("tangent_z", out_item_o.tangent_z, want.tangent_z);
          if (out_item_o.binormal_x !== want.binormal_x)
            report("binormal_x", out_item_o.binormal_x, want.binormal_x);
          if (out_item_o.binormal_y !== want.binormal_y)
            report("binormal_y", out_item_o.binormal_y, want.binormal_y);
          if (out_item_o.binormal_z !== want.binormal_z)
            report("binormal_z", out_item_o.binormal_z, want.binormal_z);
          if (out_item_o.status !== want.status)
            report("status", 16'(out_item_o.status), 16'(want.status));
        end
      end
      if (stall_cnt == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_cnt  <= $urandom_range(20, 400);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic tbn_pkg::in_item_t corner(longint x, longint y, longint z,
                                               int u, int v);
    tbn_pkg::in_item_t it;
    it.pos_x = x[31:0];
    it.pos_y = y[31:0];
    it.pos_z = z[31:0];
    it.tex_u = u[19:0];
    it.tex_v = v[19:0];
    return it;
  endfunction

  // Random corner: full range, moderate values, or small values.
  function automatic tbn_pkg::in_item_t rand_corner(int scale);
    tbn_pkg::in_item_t it;
    it.pos_x = $urandom();
    it.pos_y = $urandom();
    it.pos_z = $urandom();
    it.tex_u = 20'($urandom());
    it.tex_v = 20'($urandom());
    if (scale == 1) begin
      it.pos_x = $signed(it.pos_x) >>> 10;
      it.pos_y = $signed(it.pos_y) >>> 10;
      it.pos_z = $signed(it.pos_z) >>> 10;
      it.tex_u = $signed(it.tex_u) >>> 3;
      it.tex_v = $signed(it.tex_v) >>> 3;
    end else if (scale == 2) begin
      it.pos_x = $signed(it.pos_x) >>> 24;
      it.pos_y = $signed(it.pos_y) >>> 24;
      it.pos_z = $signed(it.pos_z) >>> 24;
      it.tex_u = $signed(it.tex_u) >>> 14;
      it.tex_v = $signed(it.tex_v) >>> 14;
    end
    return it;
  endfunction

  // Append one corner to the pending stimulus.
  task automatic add_corner(tbn_pkg::in_item_t it);
    corner_q.insert(corner_q.size(), it);
  endtask

  task automatic push_random_triangle();
    tbn_pkg::in_item_t c[3];
    int                scale;
    int                kind;
    scale = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = rand_corner(scale);
    kind = $urandom_range(0, 19);
    // Occasional degenerate shapes: repeated corner, flat texture, equal points.
    if (kind == 0) c[2] = c[$urandom_range(0, 1)];
    if (kind == 1) begin
      c[1].tex_u = c[0].tex_u;
      c[2].tex_u = c[0].tex_u;
    end
    if (kind == 2) begin
      c[1].tex_v = c[0].tex_v + (c[2].tex_v - c[0].tex_v);
      c[1].tex_u = c[0].tex_u + (c[2].tex_u - c[0].tex_u);
    end
    if (kind == 3) begin
      c[1].pos_x = c[0].pos_x;
      c[1].pos_y = c[0].pos_y;
      c[1].pos_z = c[0].pos_z;
      c[2].pos_x = c[0].pos_x;
      c[2].pos_y = c[0].pos_y;
      c[2].pos_z = c[0].pos_z;
    end
    for (int i = 0; i < 3; i++) add_corner(c[i]);
  endtask

  // Stimulus and end of run.
  initial begin
    num_errors   = 0;
    num_results  = 0;
    num_zero_det = 0;
    num_zero_len = 0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Directed triangles.
    // All zero: zero texture determinant.
    repeat (3) add_corner(corner(0, 0, 0, 0, 0));
    // One point with a valid texture: zero vector length.
    add_corner(corner(65536, -65536, 7, 0, 0));
    add_corner(corner(65536, -65536, 7, 65536, 0));
    add_corner(corner(65536, -65536, 7, 0, 65536));
    // Unit right triangle, positive determinant.
    add_corner(corner(0, 0, 0, 0, 0));
    add_corner(corner(65536, 0, 0, 65536, 0));
    add_corner(corner(0, 65536, 0, 0, 65536));
    // Same shape with swapped texture axes: negative determinant.
    add_corner(corner(0, 0, 0, 0, 0));
    add_corner(corner(65536, 0, 0, 0, 65536));
    add_corner(corner(0, 65536, 0, 65536, 0));
    // Extreme positions and texture coordinates.
    add_corner(corner(-2147483648, -2147483648, -2147483648, -524288, -524288));
    add_corner(corner(2147483647, 2147483647, -2147483648, 524287, -524288));
    add_corner(corner(2147483647, -2147483648, 2147483647, -524288, 524287));
    add_corner(corner(2147483647, 2147483647, 2147483647, 524287, 524287));
    add_corner(corner(-2147483648, 0, 2147483647, -524288, 524287));
    add_corner(corner(-1, 1, 2147483647, 524287, -524288));
    // Distinct points with flat texture: zero determinant.
    add_corner(corner(1, 2, 3, 100, 5));
    add_corner(corner(40, -9, 77, 100, 900));
    add_corner(corner(-3000, 12, 5, 100, -4));

    // Hold off until the directed part has fully drained.
    wait (corner_q.size() == 0 && !in_valid_i && basis_q.size() == 0);
    @(negedge clk_i);

    for (int t = 0; t < NumRandomTris; t++) push_random_triangle();

    wait (corner_q.size() == 0 && !in_valid_i && basis_q.size() == 0);
    repeat (400) @(posedge clk_i);

    $display("Checked %0d triangle results (%0d zero determinant, %0d zero length).",
             num_results, num_zero_det, num_zero_len);
    $display("Directed corner cases, %0d random triangles, random bursts and stalls.",
             NumRandomTris);
    if (num_errors == 0 && basis_q.size() == 0) begin
      $display("triangle_tangent_binormal_tb OK");
    end else begin
      $display("triangle_tangent_binormal_tb NOT OK");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #4000000;
    $display("triangle_tangent_binormal_tb NOT OK");
    $finish;
  end

endmodule

// File: triangle_tangent_binormal.f
+incdir+design
design/tbn_pkg.sv
design/tbn_front.sv
design/tbn_queue.sv
design/tbn_back.sv
design/triangle_tangent_binormal.sv
tb/sv/triangle_tangent_binormal_tb.sv
